### rtl/dpr_pkg.sv
// Shared constants and codes for the Doppler profile retuner.
`default_nettype none
package dpr_pkg;

  localparam int MAX_POINTS_DEF = 256;

  localparam int TIME_W   = 24;
  localparam int SHIFT_W  = 25;
  localparam int FREQ_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int THRESH_W = 24;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd160;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage
`default_nettype wire

### rtl/dpr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module dpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/doppler_profile_retuner_top.sv
// Doppler profile retuner: point table, sequential search, interpolation and retune decision.
// Load transfer: no result. Tick transfer: an empty table gives a zero shift; when the time
// clamps to the first or last point, the walk is skipped; else up to 255 points are walked
// at one table read per cycle, then a multiply and a shift-subtract divider follow.
// One item at a time; a result waits in the output register while the next item is taken, and
// a finished tick holds while that register is full. Reset clears control state, configuration,
// last shift and the first-tune flag; the table has no clearing pass.
`default_nettype none
module doppler_profile_retuner_top
  import dpr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata fields, low to high: point_index[7:0], point_time[31:8], point_shift[56:32],
  // elapsed_time[80:57], zero fill [87:81]
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser fields: op[0]
  input  wire logic [0:0]            s_tuser,
  // m_tdata fields, low to high: shift_now[24:0], tuned_freq[56:25], retune[57],
  // pass_done[58], zero fill [63:59]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW        = $clog2(MAX_POINTS);
  localparam int ENTRY_W   = TIME_W + SHIFT_W;
  localparam int CNT_LIM   = (MAX_POINTS < 256) ? MAX_POINTS : 256;
  localparam int DDIFF_W   = SHIFT_W + 1;
  localparam int PROD_W    = TIME_W + 1 + DDIFF_W;
  localparam int DVD_W     = PROD_W - 2;
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int Q_W       = SHIFT_W + 2;
  localparam int SUM_W     = FREQ_W + 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST_RD,
    S_FIRST_RD,
    S_FIRST_CHK,
    S_WALK,
    S_MUL,
    S_ABS,
    S_DIV,
    S_FIX,
    S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [FREQ_W-1:0]   center_freq;
  logic [COUNT_W-1:0]  point_count;
  logic [THRESH_W-1:0] change_threshold;

  // tracking state
  logic [SHIFT_W-1:0] last_shift;
  logic               tuned_once;

  // tick working registers
  logic [TIME_W-1:0]      t_r;
  logic [COUNT_W-1:0]     n_r;
  logic [AW-1:0]          rd_addr;
  logic [COUNT_W-1:0]     walk_idx;
  logic [TIME_W-1:0]      last_t;
  logic [SHIFT_W-1:0]     last_d;
  logic                   done_r;
  logic [TIME_W-1:0]      prev_t;
  logic [SHIFT_W-1:0]     prev_d;
  logic [TIME_W-1:0]      tdiff_r;
  logic [TIME_W-1:0]      den_r;
  logic [DDIFF_W-1:0]     ddiff_r;
  logic [PROD_W-1:0]      prod_r;
  logic                   neg_r;
  logic [DVD_W-1:0]       dvd;
  logic [TIME_W-1:0]      rem;
  logic [STEP_W-1:0]      step;
  logic [SHIFT_W-1:0]     shift_r;

  // input fields
  logic                in_op;
  logic [7:0]          in_index;
  logic [TIME_W-1:0]   in_time;
  logic [SHIFT_W-1:0]  in_shift;
  logic [TIME_W-1:0]   in_elapsed;

  assign in_op      = s_tuser[0];
  assign in_index   = s_tdata[7:0];
  assign in_time    = s_tdata[31:8];
  assign in_shift   = s_tdata[56:32];
  assign in_elapsed = s_tdata[80:57];

  logic in_xfer;
  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  // table RAM: shift in the upper bits, time in the lower
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]  rd_t;
  logic [SHIFT_W-1:0] rd_d;

  assign ram_we    = in_xfer && (in_op == OP_LOAD) &&
                     ({24'd0, in_index} < 32'(MAX_POINTS));
  assign ram_waddr = AW'(in_index);
  assign ram_wdata = {in_shift, in_time};
  assign rd_t      = ram_rdata[TIME_W-1:0];
  assign rd_d      = ram_rdata[ENTRY_W-1:TIME_W];

  dpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // effective point count
  logic [COUNT_W-1:0] n_eff;
  assign n_eff = (point_count > COUNT_W'(CNT_LIM)) ? COUNT_W'(CNT_LIM) : point_count;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // multiplier: (t - t0) * (d1 - d0)
  logic signed [PROD_W-1:0] prod_c;
  assign prod_c = $signed({1'b0, tdiff_r}) * $signed(ddiff_r);

  logic [PROD_W-1:0] prod_mag;
  assign prod_mag = prod_r[PROD_W-1] ? (~prod_r + PROD_W'(1)) : prod_r;

  // divider step: shift in one dividend bit, trial subtract
  logic [TIME_W:0] r_sh;
  logic            r_ge;
  logic [TIME_W:0] r_sub;
  assign r_sh  = {rem, dvd[DVD_W-1]};
  assign r_ge  = (r_sh >= {1'b0, den_r});
  assign r_sub = r_sh - {1'b0, den_r};

  // floor correction of the quotient
  logic [Q_W-1:0] q_mag;
  logic [Q_W-1:0] q_adj;
  logic [Q_W-1:0] q_val;
  assign q_mag = {1'b0, dvd[Q_W-2:0]};
  assign q_adj = q_mag + Q_W'(rem != '0);
  assign q_val = neg_r ? (~q_adj + Q_W'(1)) : q_mag;

  // frequency and retune decision
  logic [SUM_W-1:0]   sum_c;
  logic [FREQ_W-1:0]  freq_c;
  logic [DDIFF_W-1:0] diff_c;
  logic [DDIFF_W-1:0] absd_c;
  logic               retune_c;
  logic               out_free;

  assign sum_c  = {2'b00, center_freq, 4'b0000} +
                  {{(SUM_W-SHIFT_W){shift_r[SHIFT_W-1]}}, shift_r};
  assign freq_c = sum_c[SUM_W-1] ? '0 :
                  (sum_c[SUM_W-2] ? '1 : sum_c[FREQ_W+3:4]);
  assign diff_c = {shift_r[SHIFT_W-1], shift_r} - {last_shift[SHIFT_W-1], last_shift};
  assign absd_c = diff_c[DDIFF_W-1] ? (~diff_c + DDIFF_W'(1)) : diff_c;
  assign retune_c = !done_r && ((absd_c > {2'b00, change_threshold}) || !tuned_once);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      center_freq      <= '0;
      point_count      <= '0;
      change_threshold <= THRESH_RESET;
      last_shift       <= '0;
      tuned_once       <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER: center_freq      <= cfg_data[FREQ_W-1:0];
          REG_COUNT:  point_count      <= cfg_data[COUNT_W-1:0];
          REG_THRESH: change_threshold <= cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end

      // in S_FINISH the output register is reloaded below instead
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer && (in_op == OP_TICK)) begin
            t_r <= in_elapsed;
            n_r <= n_eff;
            if (n_eff == '0) begin
              shift_r <= '0;
              done_r  <= (in_elapsed != '0);
              state   <= S_FINISH;
            end else begin
              rd_addr <= AW'(n_eff - COUNT_W'(1));
              state   <= S_LAST_RD;
            end
          end
        end
        S_LAST_RD: begin
          rd_addr <= '0;
          state   <= S_FIRST_RD;
        end
        S_FIRST_RD: begin
          // last point arrives
          last_t  <= rd_t;
          last_d  <= rd_d;
          done_r  <= (t_r > rd_t);
          rd_addr <= AW'(1);
          state   <= S_FIRST_CHK;
        end
        S_FIRST_CHK: begin
          if (t_r <= rd_t) begin
            shift_r <= rd_d;
            state   <= S_FINISH;
          end else if (t_r >= last_t) begin
            shift_r <= last_d;
            state   <= S_FINISH;
          end else begin
            prev_t   <= rd_t;
            prev_d   <= rd_d;
            rd_addr  <= AW'(2);
            walk_idx <= COUNT_W'(1);
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          // one entry per cycle; the read of the next entry is already in flight
          if (t_r <= rd_t) begin
            tdiff_r <= t_r - prev_t;
            den_r   <= rd_t - prev_t;
            ddiff_r <= {rd_d[SHIFT_W-1], rd_d} - {prev_d[SHIFT_W-1], prev_d};
            state   <= S_MUL;
          end else begin
            prev_t   <= rd_t;
            prev_d   <= rd_d;
            rd_addr  <= rd_addr + AW'(1);
            walk_idx <= walk_idx + COUNT_W'(1);
          end
        end
        S_MUL: begin
          prod_r <= prod_c;
          state  <= S_ABS;
        end
        S_ABS: begin
          neg_r <= prod_r[PROD_W-1];
          dvd   <= prod_mag[DVD_W-1:0];
          rem   <= '0;
          step  <= STEP_W'(DIV_STEPS);
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= r_ge ? r_sub[TIME_W-1:0] : r_sh[TIME_W-1:0];
          dvd  <= {dvd[DVD_W-2:0], r_ge};
          step <= step - STEP_W'(1);
          if (step == STEP_W'(1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          shift_r <= SHIFT_W'({{(Q_W-SHIFT_W){prev_d[SHIFT_W-1]}}, prev_d} + q_val);
          state   <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b00000, done_r, retune_c, freq_c, shift_r};
            if (retune_c) begin
              last_shift <= shift_r;
              tuned_once <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table is written only between ticks
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE))
    else $error("table write outside idle");

  // the walk always stops at or before the last point
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_idx < n_r))
    else $error("table walk ran past the point count");

  // divider leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |-> (rem < den_r))
    else $error("divider remainder not below divisor");

  // a retune result sets the first-tune flag
  a_tuned_set: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && out_free && retune_c) |=> tuned_once)
    else $error("retune did not set first-tune flag");

  // no retune once the pass is over
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[57]) |-> !m_tdata[58])
    else $error("retune flagged with pass done");

endmodule
`default_nettype wire
